// ----- rtl/core/sgr_pkg.sv -----
// sgr_pkg: shared types and constants for the stream group reverser.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package sgr_pkg;

   localparam int CSR_WIDTH = 5;
   localparam logic [CSR_WIDTH-1:0] GROUP_SIZE_RESET = CSR_WIDTH'(1);

   // controller -> datapath
   typedef struct packed {
      logic store;    // write the accepted word into the group store
      logic read;     // fetch the next drain word into the output register
      logic advance;  // output word taken, step the drain position
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic flush;    // the word being offered completes a group or ends the list
      logic last;     // the word held in the output register closes the group
   } sts_type;

endpackage

`default_nettype wire

// ----- rtl/core/sgr_req_if.sv -----
// sgr_req_if: input channel (valid/ready plus one list word).
// No dependencies.
`default_nettype none

interface sgr_req_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] item_value;
   logic                          list_end;

   modport source (output valid, output item_value, output list_end, input ready);
   modport sink   (input valid, input item_value, input list_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sgr_rsp_if.sv -----
// sgr_rsp_if: result channel (valid/ready plus one output word).
// No dependencies.
`default_nettype none

interface sgr_rsp_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] out_value;
   logic                          run_last;
   logic                          list_done;

   modport source (output valid, output out_value, output run_last, output list_done,
                   input ready);
   modport sink   (input valid, input out_value, input run_last, input list_done,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/core/stream_group_reverser.sv -----
// stream_group_reverser: buffers list words in groups of group_size, emits each
// full group newest first and a trailing partial group in arrival order.
// Each input word is accepted while idle; each drained word passes through ST_READ (group-store
// read into the output register) and ST_SHOW (offered until taken), set by the single
// registered read port. Inputs are held off while a group drains.
// Reset: synchronous; empties the buffer, sets group_size to 1; store contents undefined.
`default_nettype none

module stream_group_reverser import sgr_pkg::*; #(
   parameter int MAX_GROUP   = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   sgr_req_if.sink                   req_chan,
   sgr_rsp_if.source                 rsp_chan,
   input  wire logic                 csr_we,
   input  wire logic [CSR_WIDTH-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   sgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   sgr_dp #(
      .MAX_GROUP   (MAX_GROUP),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_value  (req_chan.item_value),
      .in_end    (req_chan.list_end),
      .out_value (rsp_chan.out_value),
      .out_last  (rsp_chan.run_last),
      .out_done  (rsp_chan.list_done)
   );

endmodule

`default_nettype wire

// ----- rtl/core/sgr_ctrl.sv -----
// sgr_ctrl: handshake state machine of the stream group reverser.
// Depends on sgr_pkg for the command and status structs.
`default_nettype none

module sgr_ctrl import sgr_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      cmd_type cmd,
   input  wire sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_SHOW = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.store   = 1'b0;
      cmd.read    = 1'b0;
      cmd.advance = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.store = 1'b1;
               if (sts.flush) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.advance = 1'b1;
               state_in    = sts.last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/sgr_dp.sv -----
// sgr_dp: group store, fill count, drain addressing and output register.
// Depends on sgr_pkg; driven by sgr_ctrl through cmd_type / sts_type.
`default_nettype none

module sgr_dp import sgr_pkg::*; #(
   parameter int MAX_GROUP   = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cmd_type                       cmd,
   output      sts_type                       sts,
   input  wire logic                          csr_we,
   input  wire logic [CSR_WIDTH-1:0]          csr_wdata,
   input  wire logic signed [VALUE_WIDTH-1:0] in_value,
   input  wire logic                          in_end,
   output      logic signed [VALUE_WIDTH-1:0] out_value,
   output      logic                          out_last,
   output      logic                          out_done
);

   localparam int CW    = $clog2(MAX_GROUP + 1);
   localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int KW    = (CW > CSR_WIDTH) ? CW : CSR_WIDTH;

   logic signed [VALUE_WIDTH-1:0] store_mem [0:MAX_GROUP-1];

   logic [CSR_WIDTH-1:0]          group_size_ff, group_size_in;
   logic [CW-1:0]                 fill_ff, fill_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [CW-1:0]                 pos_ff, pos_in;
   logic                          rev_ff, rev_in;
   logic                          end_ff, end_in;
   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic                          last_ff, done_ff;

   logic [KW-1:0]                 k_eff;
   logic [CW-1:0]                 n_now;
   logic                          full_now;
   logic [CW-1:0]                 rd_pos;
   logic                          rd_last;

   always_comb begin
      if (group_size_ff == '0) begin
         k_eff = KW'(1);
      end else if (KW'(group_size_ff) > KW'(MAX_GROUP)) begin
         k_eff = KW'(MAX_GROUP);
      end else begin
         k_eff = KW'(group_size_ff);
      end
   end

   assign n_now     = fill_ff + CW'(1);
   assign full_now  = KW'(n_now) >= k_eff;
   assign sts.flush = full_now | in_end;
   assign sts.last  = last_ff;

   // full groups drain newest first, a trailing partial group in arrival order
   assign rd_pos  = rev_ff ? (count_ff - CW'(1) - pos_ff) : pos_ff;
   assign rd_last = (pos_ff == count_ff - CW'(1));

   always_comb begin
      group_size_in = group_size_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      rev_in        = rev_ff;
      end_in        = end_ff;
      if (csr_we) begin
         group_size_in = csr_wdata;
      end
      if (cmd.store) begin
         if (sts.flush) begin
            fill_in  = '0;
            count_in = n_now;
            pos_in   = '0;
            rev_in   = full_now;
            end_in   = in_end;
         end else begin
            fill_in = n_now;
         end
      end
      if (cmd.advance) begin
         pos_in = pos_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= GROUP_SIZE_RESET;
         fill_ff       <= '0;
         count_ff      <= '0;
         pos_ff        <= '0;
         rev_ff        <= 1'b0;
         end_ff        <= 1'b0;
      end else begin
         group_size_ff <= group_size_in;
         fill_ff       <= fill_in;
         count_ff      <= count_in;
         pos_ff        <= pos_in;
         rev_ff        <= rev_in;
         end_ff        <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         store_mem[fill_ff[IDX_W-1:0]] <= in_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         value_ff <= store_mem[rd_pos[IDX_W-1:0]];
         last_ff  <= rd_last;
         done_ff  <= rd_last & end_ff;
      end
   end

   assign out_value = value_ff;
   assign out_last  = last_ff;
   assign out_done  = done_ff;

endmodule

`default_nettype wire
